[hw/rtl/cor_pkg.sv]
// Shared types and constants of the circle octant rasterizer.
`default_nettype none

package cor_pkg;

  // Command carried in the input tuser bit.
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_e;

  // Input field widths and their places in the input tdata word.
  localparam int unsigned CENTER_W   = 11;
  localparam int unsigned RADIUS_W   = 10;
  localparam int unsigned IN_CX_LSB  = 0;
  localparam int unsigned IN_CY_LSB  = IN_CX_LSB + CENTER_W;
  localparam int unsigned IN_RAD_LSB = IN_CY_LSB + CENTER_W;
  localparam int unsigned IN_DATA_W  = 32;

  // Output point coordinate width and places in the output tdata word.
  localparam int unsigned OUT_W      = 13;
  localparam int unsigned OUT_PX_LSB = 0;
  localparam int unsigned OUT_PY_LSB = OUT_PX_LSB + OUT_W;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - 2 * OUT_W;

  // Output tuser bit places.
  localparam int unsigned OUT_USER_FIN   = 0;
  localparam int unsigned OUT_USER_EMPTY = 1;
  localparam int unsigned OUT_USER_W     = 2;

  // Eight mirrored points per step, counted by a three bit index.
  localparam int unsigned NUM_POINTS  = 8;
  localparam int unsigned POINT_IDX_W = 3;

  // Step queue depth between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Decision variable constants: d0 = 3 - 2r, then +4x+6 or +4(x-y)+10.
  localparam int unsigned DEC_INIT     = 3;
  localparam int unsigned DEC_INC_HOLD = 6;
  localparam int unsigned DEC_INC_STEP = 10;

  // Flags that travel with one step record.
  typedef struct packed {
    logic done;   // circle completes with this step
    logic empty;  // no point, reply to a next with no circle in progress
  } step_flags_t;

endpackage

`default_nettype wire

[hw/rtl/cor_front.sv]
// Front part: takes commands, keeps the circle state and computes one step per transfer.
`default_nettype none

module cor_front #(
  parameter int unsigned COORD_WIDTH = 11
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  var   cor_pkg::cmd_e                   cmd_i,
  input  wire         [cor_pkg::CENTER_W-1:0]   center_x_i,
  input  wire         [cor_pkg::CENTER_W-1:0]   center_y_i,
  input  wire         [cor_pkg::RADIUS_W-1:0]   radius_i,
  input  wire                                   full_i,
  output logic                                  push_o,
  output logic        [COORD_WIDTH-1:0]         rec_cx_o,
  output logic        [COORD_WIDTH-1:0]         rec_cy_o,
  output logic        [COORD_WIDTH-1:0]         rec_x_o,
  output logic        [COORD_WIDTH-1:0]         rec_y_o,
  output cor_pkg::step_flags_t                  rec_flags_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned SW = CW + 2;  // room for x+1 and y-1 compare
  localparam int unsigned DW = CW + 3;  // decision variable width

  localparam logic [DW-1:0] DecInit = DW'(cor_pkg::DEC_INIT);
  localparam logic [DW-1:0] DecHold = DW'(cor_pkg::DEC_INC_HOLD);
  localparam logic [DW-1:0] DecStep = DW'(cor_pkg::DEC_INC_STEP);

  logic [CW-1:0] x_q, y_q, cx_q, cy_q;
  logic [DW-1:0] d_q;
  logic          active_q;

  logic          start;
  logic          empty;
  logic [CW-1:0] rad;
  logic [CW-1:0] x_cur, y_cur, cx_cur, cy_cur;
  logic [DW-1:0] d_cur, d_nxt;
  logic [SW-1:0] x_nxt, y_nxt;
  logic          done;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Select the step operands: fresh circle on start, kept state otherwise.
  always_comb begin
    start = (cmd_i == cor_pkg::CMD_START);
    empty = !start && !active_q;
    rad   = CW'(radius_i);
    if (start) begin
      x_cur  = '0;
      y_cur  = rad;
      d_cur  = DecInit - (DW'(rad) << 1);
      cx_cur = CW'(center_x_i);
      cy_cur = CW'(center_y_i);
    end else begin
      x_cur  = x_q;
      y_cur  = y_q;
      d_cur  = d_q;
      cx_cur = cx_q;
      cy_cur = cy_q;
    end
  end

  // One midpoint step: update the decision variable and the octant position.
  always_comb begin
    x_nxt = SW'(x_cur) + SW'(1);
    if (d_cur[DW-1]) begin
      d_nxt = d_cur + (DW'(x_cur) << 2) + DecHold;
      y_nxt = SW'(y_cur);
    end else begin
      d_nxt = d_cur + ((DW'(x_cur) - DW'(y_cur)) << 2) + DecStep;
      y_nxt = SW'(y_cur) - SW'(1);
    end
    done = $signed(x_nxt) > $signed(y_nxt);
  end

  // The record carries the points of the current position, before the update.
  always_comb begin
    rec_cx_o          = cx_cur;
    rec_cy_o          = cy_cur;
    rec_x_o           = x_cur;
    rec_y_o           = y_cur;
    rec_flags_o.empty = empty;
    rec_flags_o.done  = empty || done;
  end

  // Circle state, updated on every transfer that carries a real step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      d_q      <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      active_q <= 1'b0;
    end else if (push_o && !empty) begin
      x_q      <= x_nxt[CW-1:0];
      y_q      <= y_nxt[CW-1:0];
      d_q      <= d_nxt;
      cx_q     <= cx_cur;
      cy_q     <= cy_cur;
      active_q <= !done;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cor_fifo.sv]
// Short step queue between the front and the back.
`default_nettype none

module cor_fifo #(
  parameter int unsigned DATA_W = 46,
  parameter int unsigned DEPTH  = 2
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  wire  [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  wire               pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              valid_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]     count_q;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + NW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cor_back.sv]
// Back part: emits a record's eight mirrored points, one per cycle unless stalled.
`default_nettype none

module cor_back #(
  parameter int unsigned COORD_WIDTH = 11
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  head_valid_i,
  input  wire         [COORD_WIDTH-1:0]        head_cx_i,
  input  wire         [COORD_WIDTH-1:0]        head_cy_i,
  input  wire         [COORD_WIDTH-1:0]        head_x_i,
  input  wire         [COORD_WIDTH-1:0]        head_y_i,
  input  var   cor_pkg::step_flags_t           head_flags_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic signed [cor_pkg::OUT_W-1:0]     px_o,
  output logic signed [cor_pkg::OUT_W-1:0]     py_o,
  output logic                                 last_o,
  output logic                                 finished_o,
  output logic                                 empty_res_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned PW = CW + 2;
  localparam int unsigned IW = cor_pkg::POINT_IDX_W;

  logic [IW-1:0]                   idx_q;
  logic                            valid_q;
  logic signed [cor_pkg::OUT_W-1:0] px_q, py_q;
  logic                            last_q, fin_q, empty_q;

  logic          load, take, last_pt;
  logic [CW-1:0] a_sel, b_sel;
  logic [PW-1:0] px_w, py_w;

  assign load    = !valid_q || out_ready_i;
  assign take    = load && head_valid_i;
  assign last_pt = head_flags_i.empty || (idx_q == IW'(cor_pkg::NUM_POINTS - 1));
  assign pop_o   = take && last_pt;

  // Point selection: bit 2 swaps x and y, bit 0 negates the x offset,
  // bit 1 negates the y offset.
  always_comb begin
    a_sel = idx_q[2] ? head_y_i : head_x_i;
    b_sel = idx_q[2] ? head_x_i : head_y_i;
    px_w  = idx_q[0] ? PW'(head_cx_i) - PW'(a_sel) : PW'(head_cx_i) + PW'(a_sel);
    py_w  = idx_q[1] ? PW'(head_cy_i) - PW'(b_sel) : PW'(head_cy_i) + PW'(b_sel);
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (head_flags_i.empty) begin
        px_q <= '0;
        py_q <= '0;
      end else begin
        px_q <= cor_pkg::OUT_W'($signed(px_w));
        py_q <= cor_pkg::OUT_W'($signed(py_w));
      end
      last_q  <= last_pt;
      fin_q   <= head_flags_i.done;
      empty_q <= head_flags_i.empty;
    end
  end

  // Output valid and point index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= head_valid_i;
      end
      if (take) begin
        idx_q <= last_pt ? '0 : idx_q + IW'(1);
      end
    end
  end

  assign out_valid_o = valid_q;
  assign px_o        = px_q;
  assign py_o        = py_q;
  assign last_o      = last_q;
  assign finished_o  = fin_q;
  assign empty_res_o = empty_q;

endmodule

`default_nettype wire

[hw/rtl/circle_octant_rasterizer.sv]
// Top level of the circle octant rasterizer: front, step queue and point back end.
//
// Input stream: tuser bit 0 is the command (start a circle or take the next
// step); tdata carries center x, center y and radius, read on start only.
// Output stream: one point per transfer, eight per step in mirrored octant
// order, tlast on the eighth; tuser flags the step that completes the circle
// and the empty reply to a next command when no circle is in progress.
// A start transfer is accepted whenever the step queue has room; the front
// computes the step in the cycle of the transfer and writes the queue.
// The first point is registered in the step queue and then in the back end
// output register before it shows on the output. The back end sends one point
// per cycle while the receiver is ready; an empty reply is a single point.
// Up to two steps wait in the queue, so input transfers keep going while the
// receiver stalls until the queue is full; then tready drops.
// Reset clears the circle state, the queue and the output valid; a next
// command after reset gets the empty reply.
`default_nettype none

module circle_octant_rasterizer #(
  parameter int unsigned COORD_WIDTH = 11
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // center_x [10:0], center_y [21:11], radius [31:22]
  input  wire  [cor_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // cmd [0]
  input  wire  [0:0]                          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  // px [12:0], py [25:13], zero [31:26]
  output logic [cor_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // finished [0], empty_res [1]
  output logic [cor_pkg::OUT_USER_W-1:0]      m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned FLW = $bits(cor_pkg::step_flags_t);
  localparam int unsigned RW  = 4 * CW + FLW;

  logic                   push, full, pop, head_valid;
  logic [CW-1:0]          rec_cx, rec_cy, rec_x, rec_y;
  cor_pkg::step_flags_t   rec_flags;
  logic [RW-1:0]          wdata, rdata;
  logic [CW-1:0]          head_cx, head_cy, head_x, head_y;
  cor_pkg::step_flags_t   head_flags;
  logic signed [cor_pkg::OUT_W-1:0] px, py;
  logic                   fin, empty_res;

  cor_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cmd_i       (cor_pkg::cmd_e'(s_axis_tuser_i[0])),
    .center_x_i  (s_axis_tdata_i[cor_pkg::IN_CX_LSB +: cor_pkg::CENTER_W]),
    .center_y_i  (s_axis_tdata_i[cor_pkg::IN_CY_LSB +: cor_pkg::CENTER_W]),
    .radius_i    (s_axis_tdata_i[cor_pkg::IN_RAD_LSB +: cor_pkg::RADIUS_W]),
    .full_i      (full),
    .push_o      (push),
    .rec_cx_o    (rec_cx),
    .rec_cy_o    (rec_cy),
    .rec_x_o     (rec_x),
    .rec_y_o     (rec_y),
    .rec_flags_o (rec_flags)
  );

  assign wdata = {rec_flags, rec_cx, rec_cy, rec_x, rec_y};

  cor_fifo #(
    .DATA_W (RW),
    .DEPTH  (cor_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rdata),
    .valid_o (head_valid)
  );

  assign {head_flags, head_cx, head_cy, head_x, head_y} = rdata;

  cor_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cx_i    (head_cx),
    .head_cy_i    (head_cy),
    .head_x_i     (head_x),
    .head_y_i     (head_y),
    .head_flags_i (head_flags),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .px_o         (px),
    .py_o         (py),
    .last_o       (m_axis_tlast_o),
    .finished_o   (fin),
    .empty_res_o  (empty_res)
  );

  // Output word packing.
  assign m_axis_tdata_o = {{cor_pkg::OUT_PAD_W{1'b0}}, py, px};
  always_comb begin
    m_axis_tuser_o                          = '0;
    m_axis_tuser_o[cor_pkg::OUT_USER_FIN]   = fin;
    m_axis_tuser_o[cor_pkg::OUT_USER_EMPTY] = empty_res;
  end

endmodule

`default_nettype wire

[hw/rtl/cor_checker.sv]
// Port checker for the circle octant rasterizer and its bind to the top level.
`default_nettype none

module cor_checker (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 m_axis_tvalid_o,
  input wire                                 m_axis_tready_i,
  input wire [cor_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  input wire [cor_pkg::OUT_USER_W-1:0]       m_axis_tuser_o,
  input wire                                 m_axis_tlast_o
);

  // Reset leaves no result on the output.
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled output changed");

  // The empty reply is a single last, finished result at the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[cor_pkg::OUT_USER_EMPTY] |->
      m_axis_tlast_o && m_axis_tuser_o[cor_pkg::OUT_USER_FIN]
      && (m_axis_tdata_o == '0))
    else $error("malformed empty reply");

  // Points of one step follow each other directly and share the finished flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && !m_axis_tuser_o[cor_pkg::OUT_USER_EMPTY]
      && (m_axis_tuser_o[cor_pkg::OUT_USER_FIN]
          == $past(m_axis_tuser_o[cor_pkg::OUT_USER_FIN])))
    else $error("step points broken apart");

endmodule

bind circle_octant_rasterizer cor_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
